// ----- rtl/amicable_pair_check_assert.svh -----
// Assertion macros used by the checker module amic_check.
`ifndef AMICABLE_PAIR_CHECK_ASSERT_SVH
`define AMICABLE_PAIR_CHECK_ASSERT_SVH

// Check a property outside reset.
`define APC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define APC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/amic_pkg.sv -----
package amic_pkg;

  // Width of each candidate value.
  localparam int VALUE_BITS = 16;
  // Divisor sum accumulator: sigma(n) stays below 16 * n for any value here.
  localparam int SUM_BITS   = VALUE_BITS + 4;
  // Divider step counter.
  localparam int STEP_BITS  = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;

endpackage

// ----- rtl/amicable_pair_check.sv -----
// Channel   Ports                         Transaction
// --------  ----------------------------  ----------------------------------------
// command   start, busy,                  taken at an edge with start high and busy
//           first_value, second_value     low
// result    done, is_amicable             done high for one cycle; always taken
//
// Sequence: each candidate divisor d passes through the shared restoring divider
// (load, one quotient bit per cycle, evaluate). A value n runs d = 1 ..
// floor(sqrt(n)) + 1 and then a compare step; a zero value goes straight to
// the compare. When a search ends, busy drops in the same cycle that done rises.
// A mismatch on the first sum drops the second search.
// Equal values report in the cycle after the transaction, without a search.
// Reset: rst is synchronous; it returns the sequencer to idle and clears done.
// Stalls: none on the result side; done is held for exactly one cycle.
module amicable_pair_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [amic_pkg::VALUE_BITS-1:0]  first_value,
  input  logic [amic_pkg::VALUE_BITS-1:0]  second_value,
  output logic                             done,
  output logic                             is_amicable
);
  import amic_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SETUP,
    DIV,
    EVAL,
    FINISH
  } state_t;

  state_t                 state;

  // Held operands of the transaction.
  logic [VALUE_BITS-1:0]  x;
  logic [VALUE_BITS-1:0]  y;
  // Which operand is being summed: 0 first, 1 second.
  logic                   sel;
  // Value under test and current trial divisor.
  logic [VALUE_BITS-1:0]  n;
  logic [VALUE_BITS-1:0]  d;
  // Restoring divider: partial remainder, quotient / shifting dividend, step count.
  logic [VALUE_BITS-1:0]  rem;
  logic [VALUE_BITS-1:0]  quo;
  logic [STEP_BITS-1:0]   cnt;
  // Running sum of all divisors of n (n itself included).
  logic [SUM_BITS-1:0]    sum;

  logic [VALUE_BITS:0]    shifted;
  logic [VALUE_BITS:0]    diff;
  logic                   borrow;
  logic [VALUE_BITS-1:0]  cof_add;
  logic [SUM_BITS-1:0]    sum_next;
  logic [SUM_BITS-1:0]    proper;
  logic [VALUE_BITS-1:0]  other;
  logic                   sum_hit;

  assign busy = (state != IDLE);

  // One divider step: shift in the next dividend bit, try to subtract d.
  assign shifted = {rem, quo[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, d};
  assign borrow  = diff[VALUE_BITS];

  // A divisor d pairs with its cofactor n/d; add the cofactor once when it differs.
  assign cof_add  = (quo != d) ? quo : '0;
  assign sum_next = sum + SUM_BITS'(d) + SUM_BITS'(cof_add);

  // Proper divisor sum drops n itself; compare against the other operand.
  assign proper  = sum - SUM_BITS'(n);
  assign other   = sel ? x : y;
  assign sum_hit = (proper == SUM_BITS'(other));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            x <= first_value;
            y <= second_value;
            if (first_value == second_value) begin
              // Equal values never qualify: report at once.
              done        <= 1'b1;
              is_amicable <= 1'b0;
            end else begin
              sel   <= 1'b0;
              n     <= first_value;
              d     <= VALUE_BITS'(1);
              sum   <= '0;
              state <= SETUP;
            end
          end
        end
        SETUP: begin
          // Zero has no divisors: its sum stays empty.
          if (n == '0) begin
            state <= FINISH;
          end else begin
            rem   <= '0;
            quo   <= n;
            cnt   <= '0;
            state <= DIV;
          end
        end
        DIV: begin
          rem <= borrow ? shifted[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
          quo <= {quo[VALUE_BITS-2:0], ~borrow};
          cnt <= cnt + STEP_BITS'(1);
          if (cnt == STEP_BITS'(VALUE_BITS - 1)) begin
            state <= EVAL;
          end
        end
        EVAL: begin
          // n/d < d means d*d > n: every divisor pair has been seen.
          if (quo < d) begin
            state <= FINISH;
          end else begin
            if (rem == '0) begin
              sum <= sum_next;
            end
            d     <= d + VALUE_BITS'(1);
            state <= SETUP;
          end
        end
        FINISH: begin
          if (!sel && sum_hit) begin
            // First sum matches: advance to the second operand.
            sel   <= 1'b1;
            n     <= y;
            d     <= VALUE_BITS'(1);
            sum   <= '0;
            state <= SETUP;
          end else begin
            // Either a mismatch on the first sum (drop the rest) or the final check.
            done        <= 1'b1;
            is_amicable <= sel & sum_hit;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/amic_check.sv -----
module amic_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic is_amicable
);

`include "amicable_pair_check_assert.svh"

  `APC_ASSERT(a_accept_moves, (start && !busy) |=> (busy || done), "accepted transaction neither busy nor reported")
  `APC_ASSERT(a_done_idle, done |-> !busy, "result reported while busy")
  `APC_ASSERT(a_busy_ends_with_result, $fell(busy) |-> done, "busy dropped without a result")
  `APC_ASSERT(a_flag_with_done, is_amicable && !done |=> !(done && $past(!busy) && $past(!start)), "result without a transaction")
  `APC_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")

endmodule

bind amicable_pair_check amic_check u_amic_check (.*);
